// ----- hdl/lpbm_pkg.sv -----
// shared types, constants and tables for the log peak bar meter
// no dependencies
package lpbm_pkg;

  localparam int EDGE_ENTRIES = 17;
  localparam int EDGE_MAX     = 255;
  localparam int EDGE_TAB [EDGE_ENTRIES] =
    '{0, 1, 2, 3, 5, 7, 10, 14, 20, 28, 40, 54, 74, 101, 137, 187, 255};

  localparam int SAMPLE_W      = 16;
  localparam int ROW_IN_W      = 4;
  localparam int BAND_IN_W     = 4;
  localparam int IDX_W         = 8;
  localparam int PEAK_W        = 15;
  localparam int PEAK_SHIFT    = 7;
  localparam int LOG_P_W       = PEAK_W - PEAK_SHIFT;
  localparam int LOG_ENTRIES   = 2 ** LOG_P_W;
  localparam int LOG_FRAC_BITS = 13;
  localparam int LVL_W         = 16;
  localparam int GAIN_W        = 14;
  localparam int STEP_W        = 12;
  localparam int PROD_W        = GAIN_W + LVL_W;
  localparam int ROUND_BIAS    = 32768;
  localparam int BIDX_W        = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 24;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd4096;
  localparam logic [STEP_W-1:0] STEP_RESET = 12'd205;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAR_GAIN  = 8'd0,
    REG_SLEW_STEP = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_RENDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    lvl_we;
    logic                    commit;
    logic [IDX_W-1:0]        idx;
    logic [LOG_P_W-1:0]      peak;
    logic [BIDX_W-1:0]       bidx;
    logic [ROW_IN_W-1:0]     row;
    logic [BAND_IN_W-1:0]    band;
    logic                    oob;
  } cmd_t;

  typedef logic [LVL_W-1:0] log_tab_t [LOG_ENTRIES];

  function automatic int edge_of(int b);
    int r;
    if (b < EDGE_ENTRIES) begin
      r = EDGE_TAB[b];
    end else begin
      r = EDGE_MAX;
    end
    return r;
  endfunction

  // log2(p)/8 as q0.16, mantissa squared once per fraction bit
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] m;
    logic [15:0] frac;
    int          e;
    for (int p = 0; p < LOG_ENTRIES; p++) begin
      if (p < 2) begin
        tab[p] = '0;
      end else begin
        e = 0;
        for (int k = 1; k < LOG_P_W; k++) begin
          if ((p >> k) != 0) begin
            e = k;
          end
        end
        m = 64'(p) << (30 - e);
        frac = '0;
        for (int k = 0; k < LOG_FRAC_BITS; k++) begin
          m = (m * m) >> 30;
          frac = frac << 1;
          if (m >= (64'd2 << 30)) begin
            frac = frac | 16'd1;
            m = m >> 1;
          end
        end
        tab[p] = LVL_W'((e << LOG_FRAC_BITS) | int'(frac));
      end
    end
    return tab;
  endfunction

endpackage

// ----- hdl/lpbm_front.sv -----
// front end: accepts requests, tracks band peaks, emits commands
// depends on lpbm_pkg
module lpbm_front #(
  parameter int BAND_COUNT    = 16,
  parameter int FRAME_SAMPLES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid,
  output logic                                 ready,
  input  logic                                 action,
  input  logic signed [lpbm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  input  logic [lpbm_pkg::ROW_IN_W-1:0]        row,
  input  logic [lpbm_pkg::BAND_IN_W-1:0]       band,
  input  logic                                 hold,
  output logic                                 push,
  output lpbm_pkg::cmd_t                       cmd
);
  import lpbm_pkg::*;

  localparam int LIMIT_RAW = (edge_of(BAND_COUNT) < FRAME_SAMPLES) ?
                             edge_of(BAND_COUNT) : FRAME_SAMPLES;
  localparam logic [IDX_W-1:0] USED_LIM = IDX_W'(LIMIT_RAW);

  logic [IDX_W-1:0]  sample_index;
  logic [PEAK_W-1:0] band_peak;

  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [BIDX_W-1:0] b;
  logic              used;
  logic [PEAK_W-1:0] s_pos;
  logic [PEAK_W-1:0] base;
  logic [PEAK_W-1:0] pk;
  logic              done;
  logic              lvl_we;
  logic              accept;

  // band of the current sample index
  always_comb begin
    b  = '0;
    lo = '0;
    hi = IDX_W'(edge_of(1));
    for (int j = 1; j < BAND_COUNT; j++) begin
      if (IDX_W'(edge_of(j)) <= sample_index) begin
        b  = BIDX_W'(j);
        lo = IDX_W'(edge_of(j));
        hi = IDX_W'(edge_of(j + 1));
      end
    end
  end

  always_comb begin
    used   = sample_index < USED_LIM;
    s_pos  = (!sample[SAMPLE_W-1] && (sample != '0)) ? sample[PEAK_W-1:0] : '0;
    base   = (sample_index == lo) ? '0 : band_peak;
    pk     = (s_pos > base) ? s_pos : base;
    done   = (({1'b0, sample_index} + (IDX_W+1)'(1)) == {1'b0, hi}) || last;
    lvl_we = used && done;
    ready  = !hold;
    accept = valid && ready;
    push   = accept && (action || lvl_we || last);

    cmd.kind   = action ? CMD_RENDER : CMD_SAMPLE;
    cmd.lvl_we = !action && lvl_we;
    cmd.commit = !action && last;
    cmd.idx    = sample_index;
    cmd.peak   = pk[PEAK_W-1:PEAK_SHIFT];
    cmd.bidx   = b;
    cmd.row    = row;
    cmd.band   = band;
    cmd.oob    = (BIDX_W+1)'(band) >= (BIDX_W+1)'(BAND_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      band_peak    <= '0;
    end else if (accept && !action) begin
      if (last) begin
        sample_index <= '0;
        band_peak    <= '0;
      end else if (used) begin
        sample_index <= sample_index + IDX_W'(1);
        band_peak    <= pk;
      end
    end
  end

endmodule

// ----- hdl/lpbm_queue.sv -----
// short command queue between front and back
// depends on lpbm_pkg
module lpbm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpbm_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lpbm_pkg::cmd_t head
);
  import lpbm_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/lpbm_back.sv -----
// back end: level pipeline, history ring, slew-limited display memory
// depends on lpbm_pkg
module lpbm_back #(
  parameter int BAND_COUNT   = 16,
  parameter int HISTORY_ROWS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lpbm_pkg::GAIN_W-1:0]      bar_gain,
  input  logic [lpbm_pkg::STEP_W-1:0]      slew_step,
  input  logic                             q_valid,
  input  lpbm_pkg::cmd_t                   q_head,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lpbm_pkg::LVL_W-1:0]       height,
  output logic [lpbm_pkg::ROW_IN_W-1:0]    row_echo,
  output logic [lpbm_pkg::BAND_IN_W-1:0]   band_echo
);
  import lpbm_pkg::*;

  localparam int BAND_W     = $clog2(BAND_COUNT);
  localparam int ROW_W      = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
  localparam int DISP_DEPTH = HISTORY_ROWS * BAND_COUNT;
  localparam int DISP_AW    = $clog2(DISP_DEPTH);
  localparam int ROW_VALUES = 2 ** ROW_IN_W;
  localparam log_tab_t LOG_TAB = build_log_tab();

  typedef logic [BAND_COUNT-1:0][LVL_W-1:0] level_row_t;

  // memories
  logic [LVL_W-1:0] disp_mem [DISP_DEPTH];
  level_row_t       tgt_mem  [HISTORY_ROWS];

  logic [ROW_W-1:0] row_mod_lut [ROW_VALUES];

  logic [DISP_AW-1:0] clr_cnt;
  logic [ROW_W-1:0]   ptr;
  logic [LVL_W-1:0]   pending [BAND_COUNT];

  // stage 1
  logic               s1_vld;
  cmd_t               s1;
  logic [DISP_AW-1:0] s1_addr;
  logic [BAND_W-1:0]  s1_bw;
  level_row_t         tgt_rd;
  logic [LVL_W-1:0]   disp_rd;
  logic               disp_fwd;
  logic [LVL_W-1:0]   disp_fwd_val;

  // stage 2
  logic               s2_vld;
  logic               s2_lvl_we;
  logic               s2_commit;
  logic [BAND_W-1:0]  s2_b;
  logic [IDX_W-1:0]   s2_idx;
  logic [LVL_W-1:0]   s2_log;

  // stage 3
  logic               s3_vld;
  logic               s3_lvl_we;
  logic               s3_commit;
  logic [BAND_W-1:0]  s3_b;
  logic [IDX_W-1:0]   s3_idx;
  logic [PROD_W-1:0]  s3_prod;

  logic               head_render;
  logic               commit_busy;
  logic               s1_render;
  logic               s1_adv;
  logic [ROW_W-1:0]   hrow_mod;
  logic [ROW_W:0]     slot_sum;
  logic [ROW_W-1:0]   slot;
  logic [BAND_W-1:0]  hband_w;
  logic [DISP_AW-1:0] pop_addr;
  logic [LVL_W-1:0]   tgt;
  logic [LVL_W-1:0]   cur;
  logic [LVL_W-1:0]   gap;
  logic [LVL_W-1:0]   cur_new;
  logic               disp_we;
  logic               fwd;
  logic [PROD_W:0]    rounded;
  logic [LVL_W-1:0]   level;
  logic [ROW_W-1:0]   ptr_dec;
  level_row_t         row_new;
  logic               clr_in_rows;

  for (genvar i = 0; i < ROW_VALUES; i++) begin : g_row_mod
    assign row_mod_lut[i] = ROW_W'(i % HISTORY_ROWS);
  end

  // issue control
  always_comb begin
    head_render = q_head.kind == CMD_RENDER;
    commit_busy = (s1_vld && s1.commit) || (s2_vld && s2_commit) ||
                  (s3_vld && s3_commit);
    s1_render   = s1_vld && (s1.kind == CMD_RENDER);
    s1_adv      = !s1_render || !out_valid || out_ready;
    q_pop       = q_valid && !clearing && s1_adv && !(head_render && commit_busy);

    hrow_mod = row_mod_lut[q_head.row];
    slot_sum = {1'b0, ptr} + {1'b0, hrow_mod};
    if (slot_sum >= (ROW_W+1)'(HISTORY_ROWS)) begin
      slot = ROW_W'(slot_sum - (ROW_W+1)'(HISTORY_ROWS));
    end else begin
      slot = ROW_W'(slot_sum);
    end
    hband_w  = BAND_W'(q_head.band);
    pop_addr = DISP_AW'(hrow_mod) * DISP_AW'(BAND_COUNT) + DISP_AW'(hband_w);
  end

  // slew step on the displayed height
  always_comb begin
    tgt = tgt_rd[s1_bw];
    cur = disp_fwd ? disp_fwd_val : disp_rd;
    gap = (cur > tgt) ? cur - tgt : tgt - cur;
    cur_new = cur;
    if (gap > LVL_W'(slew_step)) begin
      if (cur < tgt) begin
        cur_new = cur + LVL_W'(slew_step);
      end else begin
        cur_new = cur - LVL_W'(slew_step);
      end
    end
    disp_we = s1_render && s1_adv && !s1.oob;
    fwd     = disp_we && (s1_addr == pop_addr);
  end

  // level rounding and history row build
  always_comb begin
    rounded = {1'b0, s3_prod} + (PROD_W+1)'(ROUND_BIAS);
    level   = LVL_W'(rounded >> LVL_W);
    ptr_dec = (ptr == '0) ? ROW_W'(HISTORY_ROWS - 1) : ptr - ROW_W'(1);
    for (int j = 0; j < BAND_COUNT; j++) begin
      if ((edge_of(j) < edge_of(j + 1)) && (IDX_W'(edge_of(j)) <= s3_idx)) begin
        row_new[j] = (s3_lvl_we && (s3_b == BAND_W'(j))) ? level : pending[j];
      end else begin
        row_new[j] = '0;
      end
    end
    clr_in_rows = {1'b0, clr_cnt} < (DISP_AW+1)'(HISTORY_ROWS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      ptr       <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < BAND_COUNT; j++) begin
        pending[j] <= '0;
      end
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + DISP_AW'(1);
        if (clr_cnt == DISP_AW'(DISP_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (s1_adv) begin
        s1_vld <= q_pop;
      end
      s2_vld <= s1_vld && s1_adv && (s1.kind == CMD_SAMPLE);
      s3_vld <= s2_vld;
      if (s1_render && s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s3_vld) begin
        if (s3_lvl_we) begin
          pending[s3_b] <= level;
        end
        if (s3_commit) begin
          ptr <= ptr_dec;
          for (int j = 0; j < BAND_COUNT; j++) begin
            pending[j] <= '0;
          end
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1           <= q_head;
      s1_addr      <= pop_addr;
      s1_bw        <= hband_w;
      disp_fwd     <= fwd;
      disp_fwd_val <= cur_new;
    end
    s2_lvl_we <= s1.lvl_we;
    s2_commit <= s1.commit;
    s2_b      <= BAND_W'(s1.bidx);
    s2_idx    <= s1.idx;
    s2_log    <= LOG_TAB[s1.peak];
    s3_lvl_we <= s2_lvl_we;
    s3_commit <= s2_commit;
    s3_b      <= s2_b;
    s3_idx    <= s2_idx;
    s3_prod   <= PROD_W'(bar_gain) * PROD_W'(s2_log);
    if (s1_render && s1_adv) begin
      height    <= s1.oob ? '0 : cur_new;
      row_echo  <= s1.row;
      band_echo <= s1.band;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      disp_mem[clr_cnt] <= '0;
    end else if (disp_we) begin
      disp_mem[s1_addr] <= cur_new;
    end
    if (q_pop) begin
      disp_rd <= disp_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing && clr_in_rows) begin
      tgt_mem[ROW_W'(clr_cnt)] <= '0;
    end else if (s3_vld && s3_commit) begin
      tgt_mem[ptr_dec] <= row_new;
    end
    if (q_pop) begin
      tgt_rd <= tgt_mem[slot];
    end
  end

endmodule

// ----- hdl/log_peak_bar_meter_with_slew.sv -----
// render path: command queue, stage 1, then the registered output
// throughput: one request per cycle while the queue is not full; after each
//   frame end a render waits for the level pipeline to write the new history row
// reset: synchronous; afterwards the display and history memories are
//   swept one entry per cycle through all HISTORY_ROWS*BAND_COUNT (256 by
//   default) display entries with s_axis_tready low; configuration writes are taken at once
module log_peak_bar_meter_with_slew #(
  parameter int BAND_COUNT    = 16,
  parameter int HISTORY_ROWS  = 16,
  parameter int FRAME_SAMPLES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lpbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample, row, band
  input  logic                                s_axis_tlast,  // frame_end
  input  logic                                s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lpbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // height, row_echo, band_echo
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lpbm_pkg::*;

  logic [GAIN_W-1:0]    bar_gain;
  logic [STEP_W-1:0]    slew_step;

  logic                 fe_push;
  cmd_t                 fe_cmd;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  cmd_t                 q_head;
  logic                 clearing;
  logic [LVL_W-1:0]     height;
  logic [ROW_IN_W-1:0]  row_echo;
  logic [BAND_IN_W-1:0] band_echo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_gain  <= GAIN_RESET;
      slew_step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAR_GAIN:  bar_gain  <= cfg_data[GAIN_W-1:0];
        REG_SLEW_STEP: slew_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  lpbm_front #(
    .BAND_COUNT   (BAND_COUNT),
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .valid (s_axis_tvalid),
    .ready (s_axis_tready),
    .action(s_axis_tuser),
    .sample(s_axis_tdata[SAMPLE_W-1:0]),
    .last  (s_axis_tlast),
    .row   (s_axis_tdata[SAMPLE_W +: ROW_IN_W]),
    .band  (s_axis_tdata[SAMPLE_W + ROW_IN_W +: BAND_IN_W]),
    .hold  (q_full || clearing),
    .push  (fe_push),
    .cmd   (fe_cmd)
  );

  lpbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_push),
    .push_data(fe_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  lpbm_back #(
    .BAND_COUNT  (BAND_COUNT),
    .HISTORY_ROWS(HISTORY_ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .bar_gain (bar_gain),
    .slew_step(slew_step),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .height   (height),
    .row_echo (row_echo),
    .band_echo(band_echo)
  );

  assign m_axis_tdata = {band_echo, row_echo, height};

endmodule

// ----- hdl/lpbm_checker.sv -----
// port-level checks for the log peak bar meter, bound to the top level
// depends on lpbm_pkg and log_peak_bar_meter_with_slew
module lpbm_checker #(
  parameter int BAND_COUNT = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lpbm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lpbm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result left over after reset
  a_out_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // memory sweep blocks requests right after reset
  a_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("request taken during memory sweep");

  // a band outside the meter reads as zero height
  a_band_oob: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((BIDX_W+1)'(m_axis_tdata[23:20]) >= (BIDX_W+1)'(BAND_COUNT))
    |-> m_axis_tdata[15:0] == '0)
    else $error("nonzero height for band outside the meter");

endmodule

bind log_peak_bar_meter_with_slew lpbm_checker #(.BAND_COUNT(BAND_COUNT)) u_lpbm_checker (.*);
